### rtl/core/bcbn_pkg.sv
// shared types and constants for the 1d best-candidate sample generator
// used by the controller, the datapath and the top level; no dependencies

package bcbn_pkg;

	localparam int VALUE_BITS  = 24;
	localparam int CNT_BITS    = 17;
	localparam int MULT_BITS   = 7;
	localparam int TARGET_BITS = 11;
	localparam int INDEX_BITS  = 10;
	localparam int CFG_BITS    = 11;
	localparam int OUT_BITS    = 64;

	// input item kinds, carried in tuser
	localparam logic [1:0] MODE_CAND    = 2'd0;
	localparam logic [1:0] MODE_PRELOAD = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_MULT   = 1'b0;
	localparam logic [0:0] REG_TARGET = 1'b1;

	localparam logic [MULT_BITS-1:0]   MULT_RESET   = 7'd1;
	localparam logic [TARGET_BITS-1:0] TARGET_RESET = 11'd1024;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_NB_LEFT,
		ST_NB_RIGHT,
		ST_NB_GAP,
		ST_NB_BEST,
		ST_CHECK,
		ST_WIN_VAL,
		ST_WIN_BEST,
		ST_INSERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic search_start;
		logic search_step;
		logic nb_left;
		logic nb_right;
		logic nb_gap;
		logic nb_best;
		logic win_load;
		logic win_from_best;
		logic shift;
		logic write_new;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] mode;
		logic       full;
		logic       empty;
		logic       search_done;
		logic       shift_busy;
		logic       round_end;
		logic       out_busy;
	} status_t;

endpackage

### rtl/core/best_candidate_blue_noise_1d_unit.sv
// top level of the 1d best-candidate (blue-noise) sample generator
// depends on bcbn_pkg, bcbn_ctrl, bcbn_dp and bcbn_ram
//
//  channel   signals                      payload
//  input     s_tvalid s_tready            s_tuser[1:0] mode, s_tdata[23:0] value
//  output    m_tvalid m_tready            m_tdata: value, index, gap, done
//  config    cfg_we cfg_addr cfg_data     0 candidate_multiplier, 1 target_count
//
//  a candidate passes through dispatch, a binary search of the sorted store (one
//  sorted-store read per step) and the neighbor reads and gap compare. a round's
//  winner then adds insert shifting through the single ram write port; a preload
//  costs a search plus the same shift.
//  reset clears counts and round state and restores the config defaults; the store needs no clear.
//  a waiting result holds the output register and stalls only the next emit.

module best_candidate_blue_noise_1d_unit #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bcbn_pkg::VALUE_BITS-1:0] s_tdata,   // value
	input  logic [1:0]                      s_tuser,   // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// sample_value[23:0], sample_index[33:24], chosen_gap[57:34], done_res[58]
	output logic [bcbn_pkg::OUT_BITS-1:0]   m_tdata,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_addr,
	input  logic [bcbn_pkg::CFG_BITS-1:0]   cfg_data
);

	import bcbn_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);

	cmd_t    cmd;
	status_t sts;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

	bcbn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	bcbn_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_value   (s_tdata),
		.s_mode    (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bcbn_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_tready = cmd.take;

endmodule

### rtl/core/bcbn_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module bcbn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/bcbn_ctrl.sv
// controller state machine for the best-candidate generator
// depends on bcbn_pkg (state, command and status types)

module bcbn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  bcbn_pkg::status_t sts,
	output bcbn_pkg::cmd_t    cmd
);

	import bcbn_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (sts.mode == MODE_CLEAR) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else if ((sts.mode != MODE_CAND && sts.mode != MODE_PRELOAD) || sts.full) begin
					state_d = ST_IDLE;
				end else if (sts.empty) begin
					cmd.search_start = 1'b1;
					state_d          = ST_WIN_VAL;
				end else begin
					cmd.search_start = 1'b1;
					state_d          = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (sts.search_done) begin
					state_d = (sts.mode == MODE_PRELOAD) ? ST_WIN_VAL : ST_NB_LEFT;
				end
			end
			ST_NB_LEFT: begin
				cmd.nb_left = 1'b1;
				state_d     = ST_NB_RIGHT;
			end
			ST_NB_RIGHT: begin
				cmd.nb_right = 1'b1;
				state_d      = ST_NB_GAP;
			end
			ST_NB_GAP: begin
				cmd.nb_gap = 1'b1;
				state_d    = ST_NB_BEST;
			end
			ST_NB_BEST: begin
				cmd.nb_best = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.round_end ? ST_WIN_BEST : ST_IDLE;
			end
			ST_WIN_VAL: begin
				cmd.win_load = 1'b1;
				state_d      = ST_INSERT;
			end
			ST_WIN_BEST: begin
				cmd.win_load      = 1'b1;
				cmd.win_from_best = 1'b1;
				state_d           = ST_INSERT;
			end
			ST_INSERT: begin
				// move the tail up one entry, then drop the winner into the hole
				if (sts.shift_busy) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.write_new = 1'b1;
					state_d       = (sts.mode == MODE_PRELOAD) ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/bcbn_dp.sv
// datapath: config registers, search pointers, gap arithmetic, round state,
// insert shifter and output register; depends on bcbn_pkg, drives bcbn_ram

module bcbn_dp #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bcbn_pkg::cmd_t                  cmd,
	output bcbn_pkg::status_t               sts,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_addr,
	input  logic [bcbn_pkg::CFG_BITS-1:0]   cfg_data,
	input  logic                            s_tvalid,
	input  logic [bcbn_pkg::VALUE_BITS-1:0] s_value,
	input  logic [1:0]                      s_mode,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bcbn_pkg::OUT_BITS-1:0]   m_tdata,
	output logic                            ram_we,
	output logic [$clog2(MAX_SAMPLES)-1:0]  ram_waddr,
	output logic [bcbn_pkg::VALUE_BITS-1:0] ram_wdata,
	output logic [$clog2(MAX_SAMPLES)-1:0]  ram_raddr,
	input  logic [bcbn_pkg::VALUE_BITS-1:0] ram_rdata
);

	import bcbn_pkg::*;

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int TW  = (CW > TARGET_BITS) ? CW : TARGET_BITS;
	localparam int XW  = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam int PW  = CW + MULT_BITS;
	localparam int NW  = (PW > CNT_BITS) ? PW : CNT_BITS;
	localparam int GW  = VALUE_BITS + 1;
	localparam logic [GW-1:0] V_ONE = GW'(1) << VALUE_BITS;
	localparam logic [CW-1:0] C_MAX = CW'(MAX_SAMPLES);

	// configuration
	logic [MULT_BITS-1:0]   mult_q;
	logic [TARGET_BITS-1:0] target_q;

	// item and round state
	logic [1:0]            mode_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [CNT_BITS-1:0]   cand_cnt_q;
	logic [VALUE_BITS-1:0] best_gap_q;
	logic [VALUE_BITS-1:0] best_val_q;
	logic [CW-1:0]         best_pos_q;
	logic [PW-1:0]         needed_q;

	// search and neighbor work registers
	logic [CW-1:0] lo_q, hi_q;
	logic [AW-1:0] mid_q;
	logic [GW-1:0] left_q, gap_q;

	// insert
	logic [CW-1:0]         j_q, ins_pos_q;
	logic [VALUE_BITS-1:0] win_val_q, win_gap_q;
	logic                  pend_s1;
	logic [AW-1:0]         pend_addr_s1;

	// output register
	logic                out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	// combinational helpers
	logic                 lt;
	logic [CW-1:0]        lo_n, hi_n;
	logic [CW:0]          mid_sum_n, start_sum;
	logic [GW-1:0]        left_n, right_n;
	logic [MULT_BITS-1:0] mult_eff;
	logic                 shift_more;
	logic [XW-1:0]        idx_ext;
	logic                 done_flag;

	assign lt        = ram_rdata < val_q;
	assign lo_n      = lt ? (CW'(mid_q) + CW'(1)) : lo_q;
	assign hi_n      = lt ? hi_q : CW'(mid_q);
	assign mid_sum_n = (CW+1)'(lo_n) + (CW+1)'(hi_n);
	assign start_sum = (CW+1)'(count_q);
	assign shift_more = j_q > ins_pos_q;
	assign mult_eff  = (mult_q == '0) ? MULT_BITS'(1) : mult_q;

	// toroidal distances to the neighbors on each side
	assign left_n  = (lo_q != '0) ? (GW'(val_q) - GW'(ram_rdata))
	                              : (V_ONE + GW'(val_q) - GW'(ram_rdata));
	assign right_n = (lo_q < count_q) ? (GW'(ram_rdata) - GW'(val_q))
	                                  : (V_ONE + GW'(ram_rdata) - GW'(val_q));

	assign idx_ext   = XW'(count_q) - XW'(1);
	assign done_flag = TW'(count_q) >= TW'(target_q);

	// status
	always_comb begin
		sts             = '0;
		sts.in_valid    = s_tvalid;
		sts.mode        = mode_q;
		sts.full        = (TW'(count_q) >= TW'(target_q)) || (count_q >= C_MAX);
		sts.empty       = count_q == '0;
		sts.search_done = !(lo_n < hi_n);
		sts.shift_busy  = shift_more || pend_s1;
		sts.round_end   = NW'(cand_cnt_q) >= NW'(needed_q);
		sts.out_busy    = out_valid_q && !m_tready;
	end

	// ram ports
	always_comb begin
		ram_raddr = mid_q;
		priority if (cmd.search_start) begin
			ram_raddr = start_sum[AW:1];
		end else if (cmd.search_step) begin
			ram_raddr = mid_sum_n[AW:1];
		end else if (cmd.nb_left) begin
			ram_raddr = (lo_q != '0) ? AW'(lo_q - CW'(1)) : AW'(count_q - CW'(1));
		end else if (cmd.nb_right) begin
			ram_raddr = (lo_q < count_q) ? AW'(lo_q) : '0;
		end else if (cmd.shift) begin
			ram_raddr = AW'(j_q - CW'(1));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_addr_s1;
		ram_wdata = ram_rdata;
		if (pend_s1) begin
			ram_we = 1'b1;
		end else if (cmd.write_new) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(ins_pos_q);
			ram_wdata = win_val_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q      <= MULT_RESET;
			target_q    <= TARGET_RESET;
			count_q     <= '0;
			cand_cnt_q  <= '0;
			best_gap_q  <= '0;
			best_val_q  <= '0;
			best_pos_q  <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MULT:   mult_q   <= cfg_data[MULT_BITS-1:0];
					REG_TARGET: target_q <= cfg_data[TARGET_BITS-1:0];
					default:    ;
				endcase
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.write_new) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.clear || cmd.write_new) begin
				cand_cnt_q <= '0;
				best_gap_q <= '0;
				best_val_q <= '0;
				best_pos_q <= '0;
			end else if (cmd.nb_best) begin
				cand_cnt_q <= cand_cnt_q + CNT_BITS'(1);
				if (gap_q > GW'(best_gap_q)) begin
					best_gap_q <= gap_q[VALUE_BITS-1:0];
					best_val_q <= val_q;
					best_pos_q <= lo_q;
				end
			end
			pend_s1 <= cmd.shift && shift_more;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take && s_tvalid) begin
			mode_q <= s_mode;
			val_q  <= s_value;
		end
		if (cmd.search_start) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			mid_q <= start_sum[AW:1];
		end else if (cmd.search_step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_sum_n[AW:1];
		end
		if (cmd.nb_left) begin
			needed_q <= PW'(count_q) * PW'(mult_eff);
		end
		if (cmd.nb_right) begin
			left_q <= left_n;
		end
		if (cmd.nb_gap) begin
			gap_q <= (left_q < right_n) ? left_q : right_n;
		end
		if (cmd.win_load) begin
			j_q <= count_q;
			if (cmd.win_from_best) begin
				win_val_q <= best_val_q;
				win_gap_q <= best_gap_q;
				ins_pos_q <= best_pos_q;
			end else begin
				win_val_q <= val_q;
				win_gap_q <= '0;
				ins_pos_q <= lo_q;
			end
		end else if (cmd.shift && shift_more) begin
			j_q <= j_q - CW'(1);
		end
		pend_addr_s1 <= AW'(j_q);
		if (cmd.emit) begin
			out_data_q <= OUT_BITS'({done_flag, win_gap_q, idx_ext[INDEX_BITS-1:0], win_val_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### rtl/core/bcbn_checker.sv
// port-level checks for the best-candidate generator, bound to the top level
// depends on bcbn_pkg for widths

module bcbn_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [1:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bcbn_pkg::OUT_BITS-1:0]   m_tdata
);

	import bcbn_pkg::*;

	// a result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// every item goes through dispatch before the next one can be taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a new result is loaded only while the block is busy with an item
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

	// a clear or ignored item, taken while no result is offered, brings no result once its dispatch is over
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_CAND && s_tuser != MODE_PRELOAD
		&& !m_tvalid |=> ##1 !m_tvalid)
		else $error("result after a clear or ignored item");

endmodule

bind best_candidate_blue_noise_1d_unit bcbn_checker u_bcbn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### bench/best_candidate_blue_noise_1d_unit_test.sv
// self-checking bench for the 1d best-candidate sample generator: a scoreboard class
// predicts every emitted sample while plain tasks drive the stream and config ports
// depends on bcbn_pkg and best_candidate_blue_noise_1d_unit
`timescale 1ns / 100ps

module best_candidate_blue_noise_1d_unit_test;
	import bcbn_pkg::*;

	localparam int          SAMPLE_CAP    = 1024;
	localparam logic [1:0]  MODE_IGNORED  = 2'd3;
	localparam int          SETTLE_CYCLES = 1200;
	localparam int          CYCLE_LIMIT   = 2000000;

	localparam int STALL_NONE   = 0;
	localparam int STALL_RANDOM = 1;
	localparam int STALL_ONE_IN_FOUR = 2;

	// one emitted sample, laid out as m_tdata from bit 0 up
	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] gap;
		logic [INDEX_BITS-1:0] index;
		logic [VALUE_BITS-1:0] value;
	} sample_rec_t;

	class sample_scoreboard;
		logic [VALUE_BITS-1:0]  store [SAMPLE_CAP];
		int unsigned            count;
		int unsigned            tried;
		logic [VALUE_BITS-1:0]  best_gap;
		logic [VALUE_BITS-1:0]  best_value;
		int unsigned            best_pos;
		logic [MULT_BITS-1:0]   mult;
		logic [TARGET_BITS-1:0] target;
		sample_rec_t            sample_q [$];
		int                     errors;

		function new();
			count = 0;
			mult = MULT_RESET;
			target = TARGET_RESET;
			errors = 0;
			restart_round();
		endfunction

		function void restart_round();
			tried = 0;
			best_gap = '0;
			best_value = '0;
			best_pos = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [CFG_BITS-1:0] data);
			if (idx == REG_MULT)
				mult = data[MULT_BITS-1:0];
			else
				target = data[TARGET_BITS-1:0];
		endfunction

		function bit is_full();
			return (count >= target) || (count >= SAMPLE_CAP);
		endfunction

		function int unsigned pending();
			return sample_q.size();
		endfunction

		function int unsigned first_at_or_above(logic [VALUE_BITS-1:0] v);
			int unsigned lo, hi, mid;
			lo = 0;
			hi = count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (store[mid] < v)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function void insert_sorted(int unsigned pos, logic [VALUE_BITS-1:0] v);
			int unsigned i;
			if (pos > count)
				pos = count;
			if (count >= SAMPLE_CAP)
				return;
			for (i = count; i > pos; i--)
				store[i] = store[i-1];
			store[pos] = v;
			count++;
		endfunction

		function void push_sample(int unsigned idx, logic [VALUE_BITS-1:0] v,
				logic [VALUE_BITS-1:0] g);
			sample_rec_t s;
			s.value = v;
			s.index = idx[INDEX_BITS-1:0];
			s.gap = g;
			s.done = (count >= target);
			sample_q = {sample_q, s};
		endfunction

		// returns 1 when the transaction changed the sample set or the round
		function bit note_input(logic [1:0] mode, logic [VALUE_BITS-1:0] v);
			int unsigned          pos, idx;
			logic [VALUE_BITS:0]  left, right, gap;
			logic [31:0]          needed;
			if (mode == MODE_CLEAR) begin
				count = 0;
				restart_round();
				return 1;
			end
			if (mode == MODE_IGNORED || is_full())
				return 0;
			if (mode == MODE_PRELOAD) begin
				insert_sorted(first_at_or_above(v), v);
				restart_round();
				return 1;
			end
			if (count == 0) begin
				insert_sorted(0, v);
				restart_round();
				push_sample(0, v, '0);
				return 1;
			end
			pos = first_at_or_above(v);
			// toroidal distances wrap through 1.0 at either end of the store
			if (pos > 0)
				left = {1'b0, v} - {1'b0, store[pos-1]};
			else
				left = {1'b1, {VALUE_BITS{1'b0}}} + {1'b0, v} - {1'b0, store[count-1]};
			if (pos < count)
				right = {1'b0, store[pos]} - {1'b0, v};
			else
				right = {1'b1, {VALUE_BITS{1'b0}}} + {1'b0, store[0]} - {1'b0, v};
			gap = (left < right) ? left : right;
			if (gap > {1'b0, best_gap}) begin
				best_gap = gap[VALUE_BITS-1:0];
				best_value = v;
				best_pos = pos;
			end
			tried = (tried + 1) & 32'h1FFFF;
			needed = count * ((mult == 0) ? 1 : mult);
			if (tried >= needed) begin
				idx = count;
				insert_sorted(best_pos, best_value);
				push_sample(idx, best_value, best_gap);
				restart_round();
			end
			return 1;
		endfunction

		function void check_result(sample_rec_t got);
			sample_rec_t want;
			if (sample_q.size() == 0) begin
				$display("%0t unexpected sample: value %h index %0d gap %h done %b",
					$time, got.value, got.index, got.gap, got.done);
				errors++;
				return;
			end
			want = sample_q.pop_front();
			if (got.value !== want.value) begin
				$display("%0t sample_value: expected %h, got %h", $time, want.value, got.value);
				errors++;
			end
			if (got.index !== want.index) begin
				$display("%0t sample_index: expected %0d, got %0d", $time, want.index, got.index);
				errors++;
			end
			if (got.gap !== want.gap) begin
				$display("%0t chosen_gap: expected %h, got %h", $time, want.gap, got.gap);
				errors++;
			end
			if (got.done !== want.done) begin
				$display("%0t done_res: expected %b, got %b", $time, want.done, got.done);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VALUE_BITS-1:0] s_tdata  = '0;   // value
	logic [1:0]            s_tuser  = '0;   // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// sample_value[23:0], sample_index[33:24], chosen_gap[57:34], done_res[58]
	logic [OUT_BITS-1:0]   m_tdata;
	logic                  cfg_we   = 1'b0;
	logic [0:0]            cfg_addr = '0;
	logic [CFG_BITS-1:0]   cfg_data = '0;

	sample_scoreboard sb = new();
	int unsigned      burst_left = 0;
	int unsigned      cycle_count = 0;
	logic [15:0]      rx_cycle = '0;
	int               rx_style = STALL_NONE;

	best_candidate_blue_noise_1d_unit #(.MAX_SAMPLES(SAMPLE_CAP)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stall pattern, picked anew at random whenever the low byte of rx_cycle is zero
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1'b1;
		if (rx_cycle[7:0] == 8'd0)
			rx_style <= $urandom_range(0, 3);
		case (rx_style)
			STALL_NONE: m_tready <= 1'b1;
			STALL_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			STALL_ONE_IN_FOUR: m_tready <= (rx_cycle[1:0] != 2'd3);
			default: m_tready <= (rx_cycle % 5 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[$bits(sample_rec_t)-1:0]);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input logic [0:0] idx, input int unsigned data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data[CFG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, data[CFG_BITS-1:0]);
	endtask

	task automatic send_item(input logic [1:0] mode, input logic [VALUE_BITS-1:0] v,
			output bit took);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		took = sb.note_input(mode, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(9, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// no config write until every sample is out and the last insert shift is over
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned mult, input int unsigned target,
			input int n_items, input int preload_pct, input int clear_pct);
		int         taken;
		int         pick;
		bit         took;
		logic [1:0] mode;
		logic [VALUE_BITS-1:0] v;
		settle();
		write_reg(REG_MULT, mult);
		write_reg(REG_TARGET, target);
		taken = 0;
		while (taken < n_items) begin
			pick = $urandom_range(0, 99);
			if (sb.is_full() && $urandom_range(0, 3) != 0)
				mode = MODE_CLEAR;
			else if (pick < clear_pct)
				mode = MODE_CLEAR;
			else if (pick < clear_pct + 3)
				mode = MODE_IGNORED;
			else if (pick < clear_pct + 3 + preload_pct)
				mode = MODE_PRELOAD;
			else
				mode = MODE_CAND;
			pick = $urandom_range(0, 15);
			if (pick == 0)
				v = '0;
			else if (pick == 1)
				v = '1;
			else if (pick <= 3 && sb.count > 0)
				v = sb.store[$urandom_range(0, sb.count - 1)];
			else
				v = VALUE_BITS'($urandom);
			send_item(mode, v, took);
			if (took)
				taken++;
		end
	endtask

	initial begin
		bit took;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: multiplier 1, target 1024
		// lone first sample, then a duplicate round with no positive gap
		send_item(MODE_CAND, 24'h000000, took);
		send_item(MODE_CAND, 24'h000000, took);
		send_item(MODE_IGNORED, 24'hFFFFFF, took);
		send_item(MODE_CLEAR, 24'h000000, took);
		send_item(MODE_CAND, 24'hFFFFFF, took);
		send_item(MODE_CAND, 24'h800000, took);
		send_item(MODE_PRELOAD, 24'h400000, took);
		send_item(MODE_CAND, 24'hC00000, took);
		send_item(MODE_CAND, 24'h200000, took);
		send_item(MODE_CAND, 24'h600000, took);
		send_item(MODE_PRELOAD, 24'hFFFFFF, took);
		send_item(MODE_CAND, 24'h000001, took);

		// multiplier zero acts as one; target reached drops candidates and preloads
		settle();
		write_reg(REG_MULT, 0);
		write_reg(REG_TARGET, 2);
		send_item(MODE_CLEAR, 24'h000000, took);
		send_item(MODE_CAND, 24'h123456, took);
		send_item(MODE_CAND, 24'hABCDEF, took);
		send_item(MODE_CAND, 24'h555555, took);
		send_item(MODE_PRELOAD, 24'h0F0F0F, took);
		send_item(MODE_CLEAR, 24'hFFFFFF, took);
		send_item(MODE_CAND, 24'h7FFFFF, took);

		// target zero: the set counts as full from the start
		settle();
		write_reg(REG_TARGET, 0);
		send_item(MODE_CLEAR, 24'h000000, took);
		send_item(MODE_CAND, 24'h3C3C3C, took);
		send_item(MODE_PRELOAD, 24'hC3C3C3, took);
		send_item(MODE_IGNORED, 24'h000000, took);

		random_phase(1, 1024, 300, 5, 3);
		random_phase(64, 6, 150, 3, 1);
		random_phase(0, 16, 100, 5, 3);
		random_phase(3, 40, 150, 10, 2);
		random_phase(2, 1024, 150, 45, 1);
		random_phase(1, 1024, 80, 0, 0);

		settle();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### best_candidate_blue_noise_1d_unit.f
rtl/core/bcbn_pkg.sv
rtl/core/bcbn_ram.sv
rtl/core/bcbn_ctrl.sv
rtl/core/bcbn_dp.sv
rtl/core/best_candidate_blue_noise_1d_unit.sv
rtl/core/bcbn_checker.sv
bench/best_candidate_blue_noise_1d_unit_test.sv
